### sv/battery_switch_state_machine_top_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef BATTERY_SWITCH_STATE_MACHINE_TOP_DEFINES_SVH
`define BATTERY_SWITCH_STATE_MACHINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bssm_pkg.sv
package bssm_pkg;

	localparam int FLAG_BITS = 32;
	localparam int FAULT_W = 32;
	localparam int CNT_W = 16;
	localparam int OCB_W = 5;
	localparam int IDX_W = 3;

	// Fault bits at or above FLAG_BITS are ignored.
	localparam logic [FAULT_W-1:0] FLAG_MASK = (FLAG_BITS >= FAULT_W) ? {FAULT_W{1'b1}} :
		FAULT_W'((64'd1 << FLAG_BITS) - 64'd1);

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_CHG    = 2'd1,
		MODE_DIS    = 2'd2,
		MODE_NORMAL = 2'd3
	} bssm_mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CHG_MASK  = 3'd0,
		REG_DIS_MASK  = 3'd1,
		REG_OC_BIT    = 3'd2,
		REG_PRE_TICKS = 3'd3,
		REG_HOLD_TICKS = 3'd4
	} bssm_reg_t;

	localparam logic [FAULT_W-1:0] RST_CHG_MASK = 32'hFFFF_FFFF;
	localparam logic [FAULT_W-1:0] RST_DIS_MASK = 32'hFFFF_FFFF;
	localparam logic [OCB_W-1:0] RST_OC_BIT = 5'd4;
	localparam logic [CNT_W-1:0] RST_PRE_TICKS = 16'd1000;
	localparam logic [CNT_W-1:0] RST_HOLD_TICKS = 16'd500;

	typedef struct packed {
		logic [FAULT_W-1:0] chg_mask;
		logic [FAULT_W-1:0] dis_mask;
		logic [OCB_W-1:0]   oc_bit;
		logic [CNT_W-1:0]   pre_ticks;
		logic [CNT_W-1:0]   hold_ticks;
	} bssm_cfg_t;

	typedef struct packed {
		logic [FAULT_W-1:0] fault_flags;
		logic               pack_full;
		logic               pack_empty;
		logic               charge_request;
		logic               discharge_request;
		logic               startup_hold;
	} bssm_tick_t;

	typedef struct packed {
		bssm_mode_t mode;
		logic       charge_fet;
		logic       discharge_fet;
		logic       precharge_fet;
		logic       sequencing;
		logic       may_charge;
		logic       may_discharge;
	} bssm_result_t;

endpackage

### sv/bssm_if.sv
interface bssm_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] fault_flags;
	logic        pack_full;
	logic        pack_empty;
	logic        charge_request;
	logic        discharge_request;
	logic        startup_hold;

	modport source (output valid, fault_flags, pack_full, pack_empty, charge_request,
		discharge_request, startup_hold, input ready);
	modport sink (input valid, fault_flags, pack_full, pack_empty, charge_request,
		discharge_request, startup_hold, output ready);
endinterface

interface bssm_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       charge_fet;
	logic       discharge_fet;
	logic       precharge_fet;
	logic       sequencing;
	logic       may_charge;
	logic       may_discharge;

	modport source (output valid, mode, charge_fet, discharge_fet, precharge_fet, sequencing,
		may_charge, may_discharge, input ready);
	modport sink (input valid, mode, charge_fet, discharge_fet, precharge_fet, sequencing,
		may_charge, may_discharge, output ready);
endinterface

interface bssm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/battery_switch_state_machine_top.sv
// Battery switch state machine: charge, discharge and precharge FET sequencing.
// tick:   one request per millisecond tick (fault word, full/empty marks,
//         charge/discharge requests, startup hold), valid/ready handshake.
// result: one result per tick (mode, FET commands, sequencing flag, and the
//         charge/discharge permissions seen on that tick).
// cfg:    register writes (index, data), always ready; write only while idle.
// Path: a request taken on the tick port passes the input stage and then the
// result register (two-register path) before it shows on the result port.
// Throughput: one request per clock while the receiver is ready; the mode, window
// and holdoff update is a single pass of logic from input stage to result register.
// Stall: while the receiver holds ready low the result register keeps its
// value, one more request waits in the input stage, then tick.ready drops.
// Reset (arst_n low): mode OFF, all FETs off, counters zero, registers at
// their defaults, both stages empty.
`include "battery_switch_state_machine_top_defines.svh"

module battery_switch_state_machine_top (
	input  logic          clk,
	input  logic          arst_n,
	bssm_tick_if.sink     tick,
	bssm_result_if.source result,
	bssm_cfg_if.sink      cfg
);
	import bssm_pkg::*;

	bssm_cfg_t    regs;
	bssm_tick_t   item_s1;
	logic         vld_s1;
	bssm_result_t core_res;
	bssm_result_t res_q;
	logic         res_vld_q;
	logic         step_fire;
	logic         accept;

	bssm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bssm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (step_fire),
		.item   (item_s1),
		.regs   (regs),
		.res    (core_res)
	);

	assign step_fire = vld_s1 && (!res_vld_q || result.ready);
	assign tick.ready = !vld_s1 || step_fire;
	assign accept = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (accept)
			vld_s1 <= 1'b1;
		else if (step_fire)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.fault_flags       <= tick.fault_flags;
			item_s1.pack_full         <= tick.pack_full;
			item_s1.pack_empty        <= tick.pack_empty;
			item_s1.charge_request    <= tick.charge_request;
			item_s1.discharge_request <= tick.discharge_request;
			item_s1.startup_hold      <= tick.startup_hold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (step_fire)
			res_vld_q <= 1'b1;
		else if (result.ready)
			res_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step_fire)
			res_q <= core_res;
	end

	assign result.valid = res_vld_q;
	assign result.mode = res_q.mode;
	assign result.charge_fet = res_q.charge_fet;
	assign result.discharge_fet = res_q.discharge_fet;
	assign result.precharge_fet = res_q.precharge_fet;
	assign result.sequencing = res_q.sequencing;
	assign result.may_charge = res_q.may_charge;
	assign result.may_discharge = res_q.may_discharge;

	`BSSM_ASSERT_NEXT(a_accept_s1, accept, vld_s1, "accepted request lost at input stage")
	`BSSM_ASSERT_NEXT(a_fire_res, step_fire, res_vld_q, "stepped request gave no result")
	`BSSM_ASSERT_NEXT(a_s1_hold, vld_s1 && !step_fire, vld_s1 && $stable(item_s1),
		"waiting request changed in input stage")
endmodule

### sv/bssm_cfg.sv
module bssm_cfg (
	input  logic             clk,
	input  logic             arst_n,
	bssm_cfg_if.sink         cfg,
	output bssm_pkg::bssm_cfg_t regs
);
	import bssm_pkg::*;

	bssm_cfg_t regs_q;
	logic      wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid && cfg.ready;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.chg_mask   <= RST_CHG_MASK;
			regs_q.dis_mask   <= RST_DIS_MASK;
			regs_q.oc_bit     <= RST_OC_BIT;
			regs_q.pre_ticks  <= RST_PRE_TICKS;
			regs_q.hold_ticks <= RST_HOLD_TICKS;
		end else if (wr) begin
			case (bssm_reg_t'(cfg.index))
				REG_CHG_MASK:   regs_q.chg_mask   <= cfg.data;
				REG_DIS_MASK:   regs_q.dis_mask   <= cfg.data;
				REG_OC_BIT:     regs_q.oc_bit     <= cfg.data[OCB_W-1:0];
				REG_PRE_TICKS:  regs_q.pre_ticks  <= cfg.data[CNT_W-1:0];
				REG_HOLD_TICKS: regs_q.hold_ticks <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

### sv/bssm_core.sv
`include "battery_switch_state_machine_top_defines.svh"

module bssm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  bssm_pkg::bssm_tick_t  item,
	input  bssm_pkg::bssm_cfg_t   regs,
	output bssm_pkg::bssm_result_t res
);
	import bssm_pkg::*;

	typedef struct packed {
		bssm_mode_t       mode;
		logic             dc;    // discharge FET commanded
		logic             cf;    // charge FET
		logic             pre;   // precharge FET
		logic             turn;  // running window turns discharge on
		logic [CNT_W-1:0] wc;
		logic [CNT_W-1:0] hold;
	} bssm_state_t;

	bssm_state_t st_q, nx;
	logic [FAULT_W-1:0] faults;
	logic may_chg, may_dis, oc;
	logic call_en, call_on;

	// Discharge path sequencing: turning on or off runs a precharge window, or switches at once when ticks is zero.
	function automatic bssm_state_t dpath(bssm_state_t s, logic on, logic [CNT_W-1:0] ticks);
		bssm_state_t r;
		r = s;
		if (on) begin
			if (!s.dc) begin
				r.pre = 1'b1;
				r.turn = 1'b1;
				r.wc = ticks;
				if (ticks == '0) begin
					r.pre = 1'b0;
					r.dc = 1'b1;
					r.turn = 1'b0;
				end
			end
		end else if (!s.dc) begin
			r.pre = 1'b0;
		end else begin
			r.pre = (ticks != '0);
			r.dc = 1'b0;
			r.turn = 1'b0;
			r.wc = ticks;
		end
		return r;
	endfunction

	assign faults = item.fault_flags & FLAG_MASK;
	assign may_chg = ((faults & regs.chg_mask) == '0) && !item.pack_full && item.charge_request;
	assign may_dis = ((faults & regs.dis_mask) == '0) && !item.pack_empty
		&& item.discharge_request;
	assign oc = faults[regs.oc_bit];

	always_comb begin : next_state
		nx = st_q;
		call_en = 1'b0;
		call_on = 1'b0;
		nx.hold = (st_q.hold != '0) ? st_q.hold - 1'b1 : st_q.hold;
		if (st_q.wc != '0) begin
			nx.wc = st_q.wc - 1'b1;
			if (nx.wc == '0) begin
				nx.pre = 1'b0;
				if (st_q.turn)
					nx.dc = 1'b1;
				nx.turn = 1'b0;
			end
		end else begin
			case (st_q.mode)
				MODE_OFF: begin
					if (!item.startup_hold) begin
						call_en = 1'b1;
						call_on = may_dis;
						nx.cf = may_chg;
						// charge takes priority over discharge
						if (may_chg)
							nx.mode = MODE_CHG;
						else if (may_dis)
							nx.mode = MODE_DIS;
					end
				end
				MODE_CHG: begin
					if (!may_chg) begin
						nx.cf = 1'b0;
						call_en = 1'b1;
						nx.mode = MODE_OFF;
					end else if (may_dis) begin
						call_en = 1'b1;
						call_on = 1'b1;
						nx.mode = MODE_NORMAL;
					end
				end
				MODE_DIS: begin
					if (oc)
						nx.hold = regs.hold_ticks;
					if (!may_dis) begin
						call_en = 1'b1;
						nx.cf = 1'b0;
						nx.mode = MODE_OFF;
					end else if (may_chg && nx.hold == '0) begin
						nx.cf = 1'b1;
						nx.mode = MODE_NORMAL;
					end
				end
				MODE_NORMAL: begin
					if (!may_dis) begin
						call_en = 1'b1;
						nx.mode = MODE_CHG;
					end else if (!may_chg) begin
						nx.cf = 1'b0;
						nx.mode = MODE_DIS;
					end else begin
						call_en = 1'b1;
						call_on = 1'b1;
						nx.cf = 1'b1;
					end
				end
				default: ;
			endcase
			if (call_en)
				nx = dpath(nx, call_on, regs.pre_ticks);
		end
	end

	always_comb begin : outputs
		res.mode = nx.mode;
		res.charge_fet = nx.cf;
		res.discharge_fet = nx.dc;
		res.precharge_fet = nx.pre;
		res.sequencing = (nx.wc != '0);
		res.may_charge = may_chg;
		res.may_discharge = may_dis;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= MODE_OFF;
			st_q.dc   <= 1'b0;
			st_q.cf   <= 1'b0;
			st_q.pre  <= 1'b0;
			st_q.turn <= 1'b0;
			st_q.wc   <= '0;
			st_q.hold <= '0;
		end else if (fire) begin
			st_q <= nx;
		end
	end

	`BSSM_ASSERT_NOW(a_win_pre, st_q.wc != '0, st_q.pre, "window running without precharge FET")
	`BSSM_ASSERT_NOW(a_turn_dc, st_q.turn, !st_q.dc && st_q.wc != '0, "turn-on window state bad")
	`BSSM_ASSERT_NOW(a_cf_mode, 1'b1,
		st_q.cf == (st_q.mode == MODE_CHG || st_q.mode == MODE_NORMAL),
		"charge FET disagrees with mode")
	`BSSM_ASSERT_NEXT(a_win_hold, fire && st_q.wc > 16'd1,
		st_q.mode == $past(st_q.mode) && st_q.cf == $past(st_q.cf),
		"mode changed inside precharge window")
endmodule
